>>> rtl/cbs_pkg.sv
// cbs_pkg: shared constants and codes for the character buffer splice block
// no dependencies; used by the interfaces and the top level
`default_nettype none

package cbs_pkg;

   // buffer capacity in bytes, same for the main and the replacement buffer
   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = ADDR_W + 1;

   // fixed transaction field widths
   localparam int ACTION_W = 3;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 7;
   localparam int CNT_W    = 8;
   localparam int MLEN_W   = 8;

   // width for length arithmetic, wide enough for sums of two lengths
   localparam int CALC_W = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND_MAIN = 3'd0,
      ACT_APPEND_REPL = 3'd1,
      ACT_CLEAR_REPL  = 3'd2,
      ACT_REPLACE     = 3'd3,
      ACT_READ        = 3'd4
   } action_type;

endpackage

`default_nettype wire

>>> rtl/cbs_if.sv
// cbs_req_if / cbs_rsp_if: valid/ready channels of the buffer splice block
// depends on cbs_pkg for the field widths
`default_nettype none

interface cbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [cbs_pkg::ACTION_W-1:0]  action;
   logic [cbs_pkg::CHAR_W-1:0]    char_in;
   logic [cbs_pkg::POS_W-1:0]     position;
   logic [cbs_pkg::CNT_W-1:0]     count;

   modport source (output valid, action, char_in, position, count, input ready);
   modport sink   (input valid, action, char_in, position, count, output ready);
endinterface

interface cbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cbs_pkg::CHAR_W-1:0]    char_out;
   logic [cbs_pkg::MLEN_W-1:0]    main_length;
   logic                          accepted;

   modport source (output valid, char_out, main_length, accepted, input ready);
   modport sink   (input valid, char_out, main_length, accepted, output ready);
endinterface

`default_nettype wire

>>> rtl/cbs_ram.sv
// cbs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/char_buffer_splice.sv
// char_buffer_splice: top level, sequencer around the main and replacement rams
// depends on cbs_pkg, cbs_if (channels) and cbs_ram
`default_nettype none

// A main byte buffer and a replacement byte buffer, each up to CAPACITY bytes,
// held in two rams. Every request transaction carries one action (append to
// main, append to replacement, clear replacement, replace, read) and yields
// exactly one response transaction with the read byte, the new main length and
// an accepted flag. A replace moves the tail, the bytes behind the replaced
// span, and then copies the replacement; tail + repl_count never passes the
// new length. Both go through the single write port of the main ram, one byte
// per cycle. The response sits in an output register, so the next request is
// taken while a response still waits.
module char_buffer_splice (
   input  logic      clock,
   input  logic      reset,
   cbs_req_if.sink   req,
   cbs_rsp_if.source rsp
);

   import cbs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MOVE,
      S_COPY,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    main_count_ff, main_count_in;
   logic [LEN_W-1:0]    repl_count_ff, repl_count_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;
   logic [ADDR_W-1:0]   src_ff, src_in;
   logic [ADDR_W-1:0]   dst_ff, dst_in;
   logic [ADDR_W-1:0]   copy_dst_ff, copy_dst_in;
   logic                up_ff, up_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic                wr_repl_ff, wr_repl_in;
   logic [CHAR_W-1:0]   res_char_ff, res_char_in;
   logic                res_ok_ff, res_ok_in;
   logic [MLEN_W-1:0]   res_len_ff, res_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [MLEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic                main_we, repl_we;
   logic [ADDR_W-1:0]   main_waddr, main_raddr, repl_waddr, repl_raddr;
   logic [CHAR_W-1:0]   main_wdata, main_rdata, repl_rdata;

   logic                req_fire, out_free;
   logic [CALC_W-1:0]   pos_ext, cnt_ext, main_ext, repl_ext, end_ext, new_len;

   cbs_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_main_ram (
      .clock (clock),
      .we    (main_we),
      .waddr (main_waddr),
      .wdata (main_wdata),
      .raddr (main_raddr),
      .rdata (main_rdata)
   );

   cbs_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_repl_ram (
      .clock (clock),
      .we    (repl_we),
      .waddr (repl_waddr),
      .wdata (req.char_in),
      .raddr (repl_raddr),
      .rdata (repl_rdata)
   );

   assign req_fire = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign pos_ext  = CALC_W'(req.position);
   assign cnt_ext  = CALC_W'(req.count);
   assign main_ext = CALC_W'(main_count_ff);
   assign repl_ext = CALC_W'(repl_count_ff);
   assign end_ext  = pos_ext + cnt_ext;
   assign new_len  = main_ext - cnt_ext + repl_ext;

   always_comb begin
      state_in      = state_ff;
      main_count_in = main_count_ff;
      repl_count_in = repl_count_ff;
      remaining_in  = remaining_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      copy_dst_in   = copy_dst_ff;
      up_in         = up_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_repl_in    = wr_repl_ff;
      res_char_in   = res_char_ff;
      res_ok_in     = res_ok_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ok_in     = rsp_ok_ff;

      // a read issued last cycle lands at wr_addr_ff now
      main_we    = wr_pend_ff;
      main_waddr = wr_addr_ff;
      main_wdata = wr_repl_ff ? repl_rdata : main_rdata;
      main_raddr = src_ff;
      repl_we    = 1'b0;
      repl_waddr = ADDR_W'(repl_count_ff);
      repl_raddr = src_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_char_in = '0;
               res_ok_in   = 1'b0;
               state_in    = S_FINISH;
               case (req.action)
                  ACT_APPEND_MAIN: begin
                     if (main_count_ff < LEN_W'(CAPACITY)) begin
                        main_we       = 1'b1;
                        main_waddr    = ADDR_W'(main_count_ff);
                        main_wdata    = req.char_in;
                        main_count_in = main_count_ff + 1'b1;
                        res_ok_in     = 1'b1;
                     end
                  end
                  ACT_APPEND_REPL: begin
                     if (repl_count_ff < LEN_W'(CAPACITY)) begin
                        repl_we       = 1'b1;
                        repl_count_in = repl_count_ff + 1'b1;
                        res_ok_in     = 1'b1;
                     end
                  end
                  ACT_CLEAR_REPL: begin
                     repl_count_in = '0;
                     res_ok_in     = 1'b1;
                  end
                  ACT_REPLACE: begin
                     if (end_ext <= main_ext && new_len <= CALC_W'(CAPACITY)) begin
                        res_ok_in     = 1'b1;
                        main_count_in = LEN_W'(new_len);
                        copy_dst_in   = ADDR_W'(req.position);
                        state_in      = S_MOVE;
                        if (repl_ext < cnt_ext) begin
                           // shrink: move the tail down, lowest byte first
                           up_in        = 1'b1;
                           src_in       = ADDR_W'(end_ext);
                           dst_in       = ADDR_W'(pos_ext + repl_ext);
                           remaining_in = LEN_W'(main_ext - end_ext);
                        end else if (repl_ext > cnt_ext) begin
                           // grow: move the tail up, highest byte first
                           up_in        = 1'b0;
                           src_in       = ADDR_W'(main_ext - 1'b1);
                           dst_in       = ADDR_W'(new_len - 1'b1);
                           remaining_in = LEN_W'(main_ext - end_ext);
                        end else begin
                           remaining_in = '0;
                        end
                     end
                  end
                  ACT_READ: begin
                     main_raddr = ADDR_W'(req.position);
                     res_ok_in  = pos_ext < main_ext;
                     state_in   = S_READ;
                  end
                  default: begin
                  end
               endcase
               res_len_in = MLEN_W'(main_count_in);
            end
         end
         S_READ: begin
            res_char_in = res_ok_ff ? main_rdata : '0;
            state_in    = S_FINISH;
         end
         S_MOVE: begin
            if (remaining_ff != '0) begin
               wr_pend_in   = 1'b1;
               wr_addr_in   = dst_ff;
               wr_repl_in   = 1'b0;
               src_in       = up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
               dst_in       = up_ff ? dst_ff + 1'b1 : dst_ff - 1'b1;
               remaining_in = remaining_ff - 1'b1;
            end else begin
               remaining_in = repl_count_ff;
               src_in       = '0;
               dst_in       = copy_dst_ff;
               state_in     = S_COPY;
            end
         end
         S_COPY: begin
            if (remaining_ff != '0) begin
               wr_pend_in   = 1'b1;
               wr_addr_in   = dst_ff;
               wr_repl_in   = 1'b1;
               src_in       = src_ff + 1'b1;
               dst_in       = dst_ff + 1'b1;
               remaining_in = remaining_ff - 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_len_in   = res_len_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         main_count_ff <= '0;
         repl_count_ff <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         main_count_ff <= main_count_in;
         repl_count_ff <= repl_count_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      remaining_ff <= remaining_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      copy_dst_ff  <= copy_dst_in;
      up_ff        <= up_in;
      wr_addr_ff   <= wr_addr_in;
      wr_repl_ff   <= wr_repl_in;
      res_char_ff  <= res_char_in;
      res_ok_ff    <= res_ok_in;
      res_len_ff   <= res_len_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.char_out    = rsp_char_ff;
   assign rsp.main_length = rsp_len_ff;
   assign rsp.accepted    = rsp_ok_ff;

   // lengths never pass the capacity
   assert property (@(posedge clock) disable iff (reset)
      main_count_ff <= LEN_W'(CAPACITY) && repl_count_ff <= LEN_W'(CAPACITY))
      else $error("buffer length beyond capacity");

   // no ram write from a move or copy may still be in flight once idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_pend_ff)
      else $error("pending ram write while idle");

   // the length reported matches the stored length until the response is loaded
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH |-> res_len_ff == MLEN_W'(main_count_ff))
      else $error("result length differs from buffer length");

   // a refused transaction never returns a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.accepted |-> rsp.char_out == '0)
      else $error("refused transaction returns nonzero byte");

endmodule

`default_nettype wire
